@@ sv/rmsn_pkg.sv @@
// Shared types, constants and the name compare function for the record sorter.
// Used by rmsn_ctrl, rmsn_dpath and record_merge_sort_by_name; no dependencies.
package rmsn_pkg;

  localparam int unsigned MAX_RECORDS = 64;
  localparam int unsigned NAME_BYTES  = 20;
  localparam int unsigned IDX_W       = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH) + 1;
  localparam int unsigned NAME_W      = 160;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] name_c;
    logic [63:0] name_b;
    logic [63:0] name_a;
    logic [31:0] salary;
    logic [31:0] number;
  } record_t;

  typedef struct packed {
    logic load_we;
    idx_t load_addr;
    logic main_we;
    idx_t main_waddr;
    idx_t main_wdata;
    idx_t main_raddr;
    logic scr_we;
    idx_t scr_waddr;
    idx_t scr_wdata;
    idx_t scr_raddr_a;
    idx_t scr_raddr_b;
    idx_t name_ra;
    idx_t name_rb;
  } cmd_t;

  typedef struct packed {
    idx_t main_rdata;
    idx_t scr_rdata_a;
    idx_t scr_rdata_b;
    logic less;
  } sts_t;

  // Bytewise unsigned compare that stops at the first zero byte.
  function automatic logic name_less(input logic [NAME_W-1:0] x, input logic [NAME_W-1:0] y);
    logic       done;
    logic       res;
    logic [7:0] xb;
    logic [7:0] yb;
    done = 1'b0;
    res  = 1'b0;
    for (int p = 0; p < NAME_BYTES; p++) begin
      xb = x[NAME_W-1-8*p -: 8];
      yb = y[NAME_W-1-8*p -: 8];
      if (!done) begin
        if (xb != yb) begin
          res  = (xb < yb);
          done = 1'b1;
        end else if (xb == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

@@ sv/rmsn_dpath.sv @@
// Datapath of the record sorter: record stores, index buffers and name compare.
// Depends on rmsn_pkg; driven by rmsn_ctrl through cmd_t and sts_t.
module rmsn_dpath (
  input  logic             clk_i,
  input  rmsn_pkg::cmd_t   cmd_i,
  input  rmsn_pkg::record_t rec_i,
  output rmsn_pkg::sts_t   sts_o,
  output rmsn_pkg::record_t rec_o
);
  import rmsn_pkg::*;

  logic [63:0] name_a_mem [MAX_RECORDS];
  logic [63:0] name_b_mem [MAX_RECORDS];
  logic [31:0] name_c_mem [MAX_RECORDS];
  logic [31:0] number_mem [MAX_RECORDS];
  logic [31:0] salary_mem [MAX_RECORDS];
  idx_t        main_mem   [MAX_RECORDS];
  idx_t        scr_mem    [MAX_RECORDS];

  record_t rec_a_q;
  logic [63:0] nb_a_q, nb_b_q;
  logic [31:0] nb_c_q;
  idx_t main_rd_q, scr_rd_a_q, scr_rd_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      name_a_mem[cmd_i.load_addr] <= rec_i.name_a;
      name_b_mem[cmd_i.load_addr] <= rec_i.name_b;
      name_c_mem[cmd_i.load_addr] <= rec_i.name_c;
      number_mem[cmd_i.load_addr] <= rec_i.number;
      salary_mem[cmd_i.load_addr] <= rec_i.salary;
    end
    rec_a_q.name_a <= name_a_mem[cmd_i.name_ra];
    rec_a_q.name_b <= name_b_mem[cmd_i.name_ra];
    rec_a_q.name_c <= name_c_mem[cmd_i.name_ra];
    rec_a_q.number <= number_mem[cmd_i.name_ra];
    rec_a_q.salary <= salary_mem[cmd_i.name_ra];
    nb_a_q <= name_a_mem[cmd_i.name_rb];
    nb_b_q <= name_b_mem[cmd_i.name_rb];
    nb_c_q <= name_c_mem[cmd_i.name_rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.main_we) begin
      main_mem[cmd_i.main_waddr] <= cmd_i.main_wdata;
    end
    main_rd_q <= main_mem[cmd_i.main_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scr_we) begin
      scr_mem[cmd_i.scr_waddr] <= cmd_i.scr_wdata;
    end
    scr_rd_a_q <= scr_mem[cmd_i.scr_raddr_a];
    scr_rd_b_q <= scr_mem[cmd_i.scr_raddr_b];
  end

  assign sts_o.main_rdata  = main_rd_q;
  assign sts_o.scr_rdata_a = scr_rd_a_q;
  assign sts_o.scr_rdata_b = scr_rd_b_q;
  assign sts_o.less = name_less({rec_a_q.name_a, rec_a_q.name_b, rec_a_q.name_c},
                                {nb_a_q, nb_b_q, nb_c_q});
  assign rec_o = rec_a_q;

endmodule

@@ sv/rmsn_ctrl.sv @@
// Controller of the record sorter: load, top-down merge sort sequencing, output.
// Depends on rmsn_pkg; commands rmsn_dpath through cmd_t and reads sts_t.
module rmsn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output logic           out_last_o,
  input  logic           out_ready_i,
  input  rmsn_pkg::sts_t sts_i,
  output rmsn_pkg::cmd_t cmd_o
);
  import rmsn_pkg::*;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_POP    = 10'b0000000100,
    S_CP_RD  = 10'b0000001000,
    S_CP_WR  = 10'b0000010000,
    S_M_IDX  = 10'b0000100000,
    S_M_NAME = 10'b0001000000,
    S_M_CMP  = 10'b0010000000,
    S_O_IDX  = 10'b0100000000,
    S_O_REC  = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_RIGHT = 2'd1,
    PH_MERGE = 2'd2
  } phase_e;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  cnt_t   k_q, k_d, i_q, i_d, j_q, j_d;
  idx_t   lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  idx_t   li_q, li_d, rj_q, rj_d, r_q, r_d;
  logic   out_valid_q, out_valid_d;
  logic [SP_W-1:0] sp_q, sp_d;
  idx_t   stk_lo_q [STACK_DEPTH];
  idx_t   stk_hi_q [STACK_DEPTH];
  phase_e stk_ph_q [STACK_DEPTH];

  logic [SP_W-2:0] top;
  idx_t   t_lo, t_hi, t_mid;
  phase_e t_ph;
  logic   stk_we;
  logic [SP_W-2:0] stk_waddr;
  idx_t   stk_wlo, stk_whi;
  phase_e stk_wph;
  logic   ph_adv;
  phase_e ph_next;
  logic   take_left;
  idx_t   mid_sum;

  assign top   = sp_q[SP_W-2:0] - 1'b1;
  assign t_lo  = stk_lo_q[top];
  assign t_hi  = stk_hi_q[top];
  assign t_ph  = stk_ph_q[top];
  assign mid_sum = IDX_W'(({1'b0, t_lo} + {1'b0, t_hi}) >> 1);
  assign t_mid = mid_sum;
  assign take_left = (j_q > {1'b0, hi_q}) || ((i_q <= {1'b0, mid_q}) && sts_i.less);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; k_d = k_q; i_d = i_q; j_d = j_q;
    lo_d = lo_q; mid_d = mid_q; hi_d = hi_q;
    li_d = li_q; rj_d = rj_q; r_d = r_q;
    sp_d = sp_q;
    out_valid_d = out_valid_q;
    stk_we = 1'b0; stk_waddr = top; stk_wlo = t_lo; stk_whi = t_hi; stk_wph = t_ph;
    ph_adv = 1'b0; ph_next = t_ph;
    cmd_o = '0;
    cmd_o.load_addr  = cnt_q[IDX_W-1:0];
    cmd_o.name_ra    = r_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < cnt_t'(MAX_RECORDS)) begin
            cmd_o.load_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (in_last_i) begin
            k_d = '0;
            if (cnt_d == '0) begin
              state_d = S_LOAD;
            end else begin
              state_d = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        cmd_o.main_we    = 1'b1;
        cmd_o.main_waddr = k_q[IDX_W-1:0];
        cmd_o.main_wdata = k_q[IDX_W-1:0];
        k_d = k_q + 1'b1;
        if (k_d == cnt_q) begin
          stk_we = 1'b1; stk_waddr = '0;
          stk_wlo = '0; stk_whi = IDX_W'(cnt_q - 1'b1); stk_wph = PH_LEFT;
          sp_d = SP_W'(1);
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d = '0;
          state_d = S_O_IDX;
        end else if (t_lo >= t_hi) begin
          sp_d = sp_q - 1'b1;
        end else if (t_ph == PH_LEFT) begin
          stk_we = 1'b1; stk_wph = PH_LEFT;
          stk_waddr = sp_q[SP_W-2:0];
          stk_wlo = t_lo; stk_whi = t_mid;
          ph_adv = 1'b1; ph_next = PH_RIGHT;
          sp_d = sp_q + 1'b1;
        end else if (t_ph == PH_RIGHT) begin
          stk_we = 1'b1; stk_wph = PH_LEFT;
          stk_waddr = sp_q[SP_W-2:0];
          stk_wlo = t_mid + 1'b1; stk_whi = t_hi;
          ph_adv = 1'b1; ph_next = PH_MERGE;
          sp_d = sp_q + 1'b1;
        end else begin
          lo_d = t_lo; mid_d = t_mid; hi_d = t_hi;
          k_d = {1'b0, t_lo};
          state_d = S_CP_RD;
        end
      end
      S_CP_RD: begin
        cmd_o.main_raddr = k_q[IDX_W-1:0];
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.scr_we    = 1'b1;
        cmd_o.scr_waddr = k_q[IDX_W-1:0];
        cmd_o.scr_wdata = sts_i.main_rdata;
        if (k_q == {1'b0, hi_q}) begin
          i_d = {1'b0, lo_q};
          j_d = {1'b0, mid_q} + 1'b1;
          k_d = {1'b0, lo_q};
          state_d = S_M_IDX;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_M_IDX: begin
        cmd_o.scr_raddr_a = i_q[IDX_W-1:0];
        cmd_o.scr_raddr_b = j_q[IDX_W-1:0];
        state_d = S_M_NAME;
      end
      S_M_NAME: begin
        cmd_o.name_ra = sts_i.scr_rdata_a;
        cmd_o.name_rb = sts_i.scr_rdata_b;
        li_d = sts_i.scr_rdata_a;
        rj_d = sts_i.scr_rdata_b;
        state_d = S_M_CMP;
      end
      S_M_CMP: begin
        cmd_o.main_we    = 1'b1;
        cmd_o.main_waddr = k_q[IDX_W-1:0];
        cmd_o.main_wdata = take_left ? li_q : rj_q;
        if (take_left) begin
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (k_q == {1'b0, hi_q}) begin
          sp_d = sp_q - 1'b1;
          state_d = S_POP;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_M_IDX;
        end
      end
      S_O_IDX: begin
        cmd_o.main_raddr = k_q[IDX_W-1:0];
        if (out_valid_q) begin
          if (out_ready_i) begin
            out_valid_d = 1'b0;
            if (k_q + 1'b1 == cnt_q) begin
              cnt_d = '0;
              state_d = S_LOAD;
            end else begin
              k_d = k_q + 1'b1;
              cmd_o.main_raddr = k_d[IDX_W-1:0];
              state_d = S_O_REC;
            end
          end
        end else begin
          state_d = S_O_REC;
        end
      end
      S_O_REC: begin
        cmd_o.name_ra = sts_i.main_rdata;
        r_d = sts_i.main_rdata;
        out_valid_d = 1'b1;
        state_d = S_O_IDX;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_valid_q && (k_q + 1'b1 == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d;
    lo_q <= lo_d; mid_q <= mid_d; hi_q <= hi_d;
    li_q <= li_d; rj_q <= rj_d; r_q <= r_d;
    if (stk_we) begin
      stk_lo_q[stk_waddr] <= stk_wlo;
      stk_hi_q[stk_waddr] <= stk_whi;
    end
    for (int e = 0; e < STACK_DEPTH; e++) begin
      if (stk_we && (stk_waddr == (SP_W-1)'(e))) begin
        stk_ph_q[e] <= stk_wph;
      end else if (ph_adv && (top == (SP_W-1)'(e))) begin
        stk_ph_q[e] <= ph_next;
      end
    end
  end

endmodule

@@ sv/record_merge_sort_by_name.sv @@
// Top level: loads up to 64 records, sorts them by name with top-down merge sort.
// Steps: records are loaded, the main index buffer is initialised, then each range is
// copied to the scratch index buffer and merged back over about log2(n) levels, then the
// records are output in order; a new batch is accepted only after the last record is taken.
// Reset (rst_ni, asynchronous, active low) clears the controller and record count.
module record_merge_sort_by_name (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // employee_number, salary, name_bytes_0_7, name_bytes_8_15, name_bytes_16_19
  input  logic [223:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_employee_number, out_salary, out_name_bytes_0_7, out_name_bytes_8_15,
  // out_name_bytes_16_19
  output logic [223:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import rmsn_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  record_t rec_out;

  rmsn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmsn_dpath u_dpath (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .rec_i (record_t'(s_axis_tdata)),
    .sts_o (sts),
    .rec_o (rec_out)
  );

  assign m_axis_tdata = rec_out;

endmodule

@@ sv/rmsn_checker.sv @@
// Port-level checker for record_merge_sort_by_name, bound to the top level.
// Depends only on the top level's ports.
module rmsn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input ready while output valid");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> m_axis_tvalid) else $error("tlast without tvalid");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready to load after last word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

endmodule

bind record_merge_sort_by_name rmsn_checker u_rmsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

@@ bench/tb_sort_checker.sv @@
// Checker for record_merge_sort_by_name: watches both stream channels, predicts the
// sorted batch on each last word and compares outputs in order. Depends on rmsn_pkg.
module tb_sort_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [223:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [223:0] data;
    logic         last;
  } sorted_word_t;

  logic [223:0] batch_store[64];
  int           batch_count;
  int           order_main[64];
  int           order_scratch[64];
  sorted_word_t sorted_q[$];

  assign pending_o = sorted_q.size();

  function automatic logic [7:0] char_at(int rec, int pos);
    logic [159:0] nm;
    nm = {batch_store[rec][127:64], batch_store[rec][191:128], batch_store[rec][223:192]};
    return nm[159-8*pos -: 8];
  endfunction

  function automatic bit comes_first(int x, int y);
    logic [7:0] a;
    logic [7:0] b;
    for (int p = 0; p < rmsn_pkg::NAME_BYTES; p++) begin
      a = char_at(x, p);
      b = char_at(y, p);
      if (a != b) return a < b;
      if (a == 8'd0) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void merge_halves(int lo, int mid, int hi);
    int i;
    int j;
    int k;
    i = lo;
    j = mid + 1;
    k = lo;
    for (int t = lo; t <= hi; t++) order_scratch[t] = order_main[t];
    while (i <= mid && j <= hi) begin
      if (comes_first(order_scratch[i], order_scratch[j])) begin
        order_main[k] = order_scratch[i];
        i++;
      end else begin
        order_main[k] = order_scratch[j];
        j++;
      end
      k++;
    end
    while (i <= mid) order_main[k++] = order_scratch[i++];
    while (j <= hi) order_main[k++] = order_scratch[j++];
  endfunction

  function automatic void sort_by_name(int lo, int hi);
    int mid;
    if (lo >= hi) return;
    mid = (lo + hi) / 2;
    sort_by_name(lo, mid);
    sort_by_name(mid + 1, hi);
    merge_halves(lo, mid, hi);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    batch_count  = 0;
  end

  always @(posedge clk_i) begin
    sorted_word_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (batch_count < rmsn_pkg::MAX_RECORDS) begin
          batch_store[batch_count] = s_axis_tdata;
          batch_count++;
        end
        if (s_axis_tlast) begin
          for (int k = 0; k < batch_count; k++) order_main[k] = k;
          if (batch_count > 0) sort_by_name(0, batch_count - 1);
          for (int k = 0; k < batch_count; k++) begin
            w.data = batch_store[order_main[k]];
            w.last = (k == batch_count - 1);
            sorted_q.push_back(w);
          end
          batch_count = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          report_mismatch("output word with nothing expected");
        end else begin
          w = sorted_q.pop_front();
          if (m_axis_tdata[31:0] !== w.data[31:0])
            report_mismatch($sformatf("number %h exp %h", m_axis_tdata[31:0], w.data[31:0]));
          if (m_axis_tdata[63:32] !== w.data[63:32])
            report_mismatch($sformatf("salary %h exp %h", m_axis_tdata[63:32], w.data[63:32]));
          if (m_axis_tdata[127:64] !== w.data[127:64])
            report_mismatch($sformatf("name 0-7 %h exp %h", m_axis_tdata[127:64],
                                      w.data[127:64]));
          if (m_axis_tdata[191:128] !== w.data[191:128])
            report_mismatch($sformatf("name 8-15 %h exp %h", m_axis_tdata[191:128],
                                      w.data[191:128]));
          if (m_axis_tdata[223:192] !== w.data[223:192])
            report_mismatch($sformatf("name 16-19 %h exp %h", m_axis_tdata[223:192],
                                      w.data[223:192]));
          if (m_axis_tlast !== w.last)
            report_mismatch($sformatf("tlast %b exp %b", m_axis_tlast, w.last));
        end
      end
    end
  end
endmodule

@@ bench/tb_top.sv @@
// Testbench top for record_merge_sort_by_name: drives record batches with random
// gaps and output stalls, and reports the verdict of tb_sort_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [223:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  bit           hold_off = 1'b0;
  bit           hold_done = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  record_merge_sort_by_name i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  tb_sort_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver draws a wait before each word; a long hold-off overrides it.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
          @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !hold_off);
      end
    end
  end

  function automatic logic [159:0] pick_name(int style);
    logic [159:0] nm;
    int len;
    nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
    case (style)
      0: begin
        len = $urandom_range(0, 20);
        for (int p = 0; p < 20; p++) begin
          nm[159-8*p -: 8] = (p < len) ? 8'($urandom_range(65, 68)) : 8'd0;
        end
      end
      1: nm[159 -: 16] = 16'h4141;
      default: ;
    endcase
    return nm;
  endfunction

  task automatic send_record(input logic [159:0] nm, input logic is_last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {nm[31:0], nm[95:32], nm[159:96], $urandom, $urandom};
    s_axis_tlast  <= is_last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_batch(input int count, input int style);
    for (int k = 0; k < count; k++) send_record(pick_name(style), k == count - 1);
  endtask

  initial begin
    int sent;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: single record, two equal names, extremes, a full store with overflow.
    send_record('0, 1'b1);
    send_record({20{8'hff}}, 1'b0);
    send_record({20{8'hff}}, 1'b0);
    send_record('0, 1'b0);
    send_record({8'h41, 8'h00, {18{8'hff}}}, 1'b0);
    send_record({8'h41, 8'h00, {18{8'h11}}}, 1'b1);
    send_batch(3, 1);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_batch(68, 0);
    join
    sent = 0;
    while (sent < 320) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 10);
      send_batch(n, $urandom_range(0, 2));
      sent += n;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
